### design/brc_pkg.sv
// Shared constants, types and helpers for the rank checkpoint builder.
`timescale 1ns / 1ps
package brc_pkg;

  localparam int PILE_W   = 3;
  localparam int LEN_W    = 32;
  localparam int POS_W    = 48;
  localparam int CNT_W    = 64;
  localparam int RPC_W    = 16;
  localparam int S_DATA_W = 88;
  localparam int M_DATA_W = 8;

  localparam logic [RPC_W-1:0] RPC_RESET = 16'd2048;

  typedef enum logic [1:0] {
    SER_IDLE,
    SER_POS,
    SER_LEN,
    SER_CNT
  } ser_state_t;

  // Number of significant bytes of a count, 0..8.
  function automatic logic [3:0] sig_bytes(input logic [CNT_W-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int j = 0; j < 8; j++) begin
      if (v[8*j +: 8] != 8'd0) begin
        n = 4'(j + 1);
      end
    end
    return n;
  endfunction

endpackage

### design/bwt_rank_checkpoint_builder.sv
// Top level of the BWT rank checkpoint builder.
// The accumulator takes one run request per cycle as long as the two-record
// queue has room; a run that closes a chunk (or a finish request) pushes the
// file position and all letter counts into that queue and clears the chunk in
// the same cycle. The serializer drains one record at a time: it loads the
// record, then sends one byte per cycle while the output is taken, 8 + sum
// over letters of (1 + n) bytes. The input stalls only when two records are
// still waiting to be serialized. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module bwt_rank_checkpoint_builder #(
  parameter int ALPHABET = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [brc_pkg::RPC_W-1:0]        cfg_wdata,    // runs_per_chunk
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [brc_pkg::S_DATA_W-1:0]     s_tdata,      // pile, run_length, file_pos, pad
  input  logic                             s_tuser,      // cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [brc_pkg::M_DATA_W-1:0]     m_tdata,      // out_byte
  output logic                             m_tlast
);

  localparam int DW = brc_pkg::POS_W + ALPHABET * brc_pkg::CNT_W;

  logic [brc_pkg::RPC_W-1:0]               rpc;
  logic                                    q_push;
  logic                                    q_in_ready;
  logic [brc_pkg::POS_W-1:0]               f_pos;
  logic [ALPHABET-1:0][brc_pkg::CNT_W-1:0] f_cnt;
  logic                                    q_out_valid;
  logic                                    q_out_ready;
  logic [DW-1:0]                           q_out_data;
  logic [ALPHABET-1:0][brc_pkg::CNT_W-1:0] b_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpc <= brc_pkg::RPC_RESET;
    end else if (cfg_we) begin
      rpc <= cfg_wdata;
    end
  end

  brc_front #(.ALPHABET(ALPHABET)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rpc      (rpc),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_push),
    .q_ready  (q_in_ready),
    .q_pos    (f_pos),
    .q_cnt    (f_cnt)
  );

  brc_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_push),
    .in_ready  (q_in_ready),
    .in_data   ({f_cnt, f_pos}),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_out_data)
  );

  assign b_cnt = q_out_data[DW-1:brc_pkg::POS_W];

  brc_ser #(.ALPHABET(ALPHABET)) u_ser (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (q_out_valid),
    .rec_ready  (q_out_ready),
    .rec_pos_in (q_out_data[brc_pkg::POS_W-1:0]),
    .rec_cnt_in (b_cnt),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  a_finish_pushes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |-> q_push)
    else $error("finish request did not push a record");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_in_ready)
    else $error("record pushed into a full queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

### design/brc_front.sv
// Front end: accepts runs, accumulates per-letter counts, closes chunks.
`timescale 1ns / 1ps
module brc_front #(
  parameter int ALPHABET = 6
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [brc_pkg::RPC_W-1:0]                   rpc,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [brc_pkg::S_DATA_W-1:0]                s_tdata,
  input  logic                                        s_tuser,
  output logic                                        q_valid,
  input  logic                                        q_ready,
  output logic [brc_pkg::POS_W-1:0]                   q_pos,
  output logic [ALPHABET-1:0][brc_pkg::CNT_W-1:0]     q_cnt
);

  logic [ALPHABET-1:0][brc_pkg::CNT_W-1:0] counts;
  logic [ALPHABET-1:0][brc_pkg::CNT_W-1:0] cnt_upd;
  logic [brc_pkg::RPC_W-1:0]               runs;
  logic [brc_pkg::RPC_W-1:0]               runs_next;
  logic [brc_pkg::PILE_W-1:0]              pile;
  logic [brc_pkg::LEN_W-1:0]               len;
  logic [brc_pkg::CNT_W-1:0]               cnt_sel;
  logic [brc_pkg::CNT_W:0]                 sum;
  logic [brc_pkg::CNT_W-1:0]               sat;
  logic                                    accept;
  logic                                    close;

  assign pile   = s_tdata[2:0];
  assign len    = s_tdata[34:3];
  assign q_pos  = s_tdata[82:35];

  assign s_tready  = q_ready;
  assign accept    = s_tvalid && q_ready;
  assign runs_next = runs + 1'b1;
  assign close     = s_tuser || (runs_next == rpc);

  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      if (pile == brc_pkg::PILE_W'(i)) begin
        cnt_sel = counts[i];
      end
    end
  end

  assign sum = {1'b0, cnt_sel} + {{(brc_pkg::CNT_W + 1 - brc_pkg::LEN_W){1'b0}}, len};
  assign sat = sum[brc_pkg::CNT_W] ? '1 : sum[brc_pkg::CNT_W-1:0];

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      cnt_upd[i] = (pile == brc_pkg::PILE_W'(i)) ? sat : counts[i];
    end
  end

  assign q_valid = accept && close;
  assign q_cnt   = s_tuser ? counts : cnt_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
      runs   <= '0;
    end else if (accept) begin
      if (close) begin
        counts <= '0;
        runs   <= '0;
      end else begin
        counts <= cnt_upd;
        runs   <= runs_next;
      end
    end
  end

endmodule

### design/brc_queue.sv
// Two-entry record queue between the accumulator and the serializer.
`timescale 1ns / 1ps
module brc_queue #(
  parameter int DW = 432
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data
);

  logic [1:0][DW-1:0] mem;
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;
  logic               push;
  logic               pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### design/brc_ser.sv
// Back end: serializes one queued record into a byte stream.
`timescale 1ns / 1ps
module brc_ser #(
  parameter int ALPHABET = 6
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    rec_valid,
  output logic                                    rec_ready,
  input  logic [brc_pkg::POS_W-1:0]               rec_pos_in,
  input  logic [ALPHABET-1:0][brc_pkg::CNT_W-1:0] rec_cnt_in,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [brc_pkg::M_DATA_W-1:0]            m_tdata,
  output logic                                    m_tlast
);

  localparam int LW = $clog2(ALPHABET);
  localparam logic [LW-1:0] LAST_LETTER = LW'(ALPHABET - 1);

  brc_pkg::ser_state_t                   state;
  brc_pkg::ser_state_t                   state_next;
  logic [brc_pkg::POS_W-1:0]             rec_pos;
  logic [ALPHABET-1:0][brc_pkg::CNT_W-1:0] rec_cnt;
  logic [LW-1:0]                         letter;
  logic [2:0]                            bidx;
  logic [3:0]                            cur_n;
  logic [brc_pkg::CNT_W-1:0]             pos64;
  logic [brc_pkg::CNT_W-1:0]             cur_cnt;
  logic [3:0]                            n_now;
  logic                                  adv;
  logic                                  emit;
  logic                                  emit_last;
  logic [7:0]                            emit_byte;
  logic                                  is_last_letter;
  logic                                  cnt_done;

  assign adv            = !m_tvalid || m_tready;
  assign pos64          = {{(brc_pkg::CNT_W - brc_pkg::POS_W){1'b0}}, rec_pos};
  assign cur_cnt        = rec_cnt[letter];
  assign n_now          = brc_pkg::sig_bytes(cur_cnt);
  assign is_last_letter = (letter == LAST_LETTER);
  assign cnt_done       = ({1'b0, bidx} == (cur_n - 4'd1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      brc_pkg::SER_IDLE: begin
        if (rec_valid) state_next = brc_pkg::SER_POS;
      end
      brc_pkg::SER_POS: begin
        if (adv && bidx == 3'd7) state_next = brc_pkg::SER_LEN;
      end
      brc_pkg::SER_LEN: begin
        if (adv) begin
          if (n_now != 4'd0) begin
            state_next = brc_pkg::SER_CNT;
          end else if (is_last_letter) begin
            state_next = brc_pkg::SER_IDLE;
          end
        end
      end
      brc_pkg::SER_CNT: begin
        if (adv && cnt_done) begin
          state_next = is_last_letter ? brc_pkg::SER_IDLE : brc_pkg::SER_LEN;
        end
      end
      default: state_next = brc_pkg::SER_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rec_ready = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = 8'd0;
    unique case (state)
      brc_pkg::SER_IDLE: begin
        rec_ready = 1'b1;
      end
      brc_pkg::SER_POS: begin
        emit      = 1'b1;
        emit_byte = pos64[8*bidx +: 8];
      end
      brc_pkg::SER_LEN: begin
        emit      = 1'b1;
        emit_byte = {4'd0, n_now};
        emit_last = (n_now == 4'd0) && is_last_letter;
      end
      brc_pkg::SER_CNT: begin
        emit      = 1'b1;
        emit_byte = cur_cnt[8*bidx +: 8];
        emit_last = cnt_done && is_last_letter;
      end
      default: begin
        rec_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == brc_pkg::SER_IDLE && rec_valid) begin
      rec_pos <= rec_pos_in;
      rec_cnt <= rec_cnt_in;
    end
    if (adv && emit) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= brc_pkg::SER_IDLE;
      letter   <= '0;
      bidx     <= '0;
      cur_n    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        m_tvalid <= emit;
      end
      unique case (state)
        brc_pkg::SER_IDLE: begin
          bidx   <= '0;
          letter <= '0;
        end
        brc_pkg::SER_POS: begin
          if (adv) bidx <= bidx + 3'd1;
        end
        brc_pkg::SER_LEN: begin
          if (adv) begin
            bidx  <= '0;
            cur_n <= n_now;
            if (n_now == 4'd0 && !is_last_letter) letter <= letter + 1'b1;
          end
        end
        brc_pkg::SER_CNT: begin
          if (adv) begin
            if (cnt_done) begin
              if (!is_last_letter) letter <= letter + 1'b1;
            end else begin
              bidx <= bidx + 3'd1;
            end
          end
        end
        default: begin
          bidx <= '0;
        end
      endcase
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for bwt_rank_checkpoint_builder: runs in, record bytes checked.
`timescale 1ns / 1ps
module tb;

  localparam int ALPHABET = 6;
  localparam int REC_SETTLE = 80;
  localparam logic CMD_RUN = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
  localparam logic [brc_pkg::LEN_W-1:0] LEN_MAX = '1;
  localparam logic [brc_pkg::POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } rec_byte_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [brc_pkg::RPC_W-1:0]    cfg_wdata = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [brc_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [brc_pkg::M_DATA_W-1:0] m_tdata;
  logic                         m_tlast;

  rec_byte_t                 rec_bytes_q[$];
  logic [brc_pkg::CNT_W-1:0] letter_cnt[ALPHABET];
  logic [brc_pkg::RPC_W-1:0] chunk_run_cnt;
  logic [brc_pkg::RPC_W-1:0] chunk_runs;
  int                        src_idle_pct;
  int                        sink_idle_pct;
  int                        fail_cnt = 0;

  bwt_rank_checkpoint_builder #(.ALPHABET(ALPHABET)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // record byte checker
  always @(posedge clk) begin
    rec_byte_t exp_b;
    if (!rst && m_tvalid && m_tready) begin
      if (rec_bytes_q.size() == 0) begin
        $error("out_byte: no byte expected, got %0h (last %0b)", m_tdata, m_tlast);
        fail_cnt++;
      end else begin
        exp_b = rec_bytes_q.pop_front();
        if (m_tdata !== exp_b.value) begin
          $error("out_byte: expected %0h, got %0h", exp_b.value, m_tdata);
          fail_cnt++;
        end
        if (m_tlast !== exp_b.last) begin
          $error("last: expected %0b, got %0b", exp_b.last, m_tlast);
          fail_cnt++;
        end
      end
    end
  end

  function automatic int count_width(input logic [brc_pkg::CNT_W-1:0] v);
    int w;
    w = 0;
    for (int j = 7; j >= 0; j--) begin
      if (w == 0 && v[8*j +: 8] != 8'd0) begin
        w = j + 1;
      end
    end
    return w;
  endfunction

  function automatic void add_byte(input logic [7:0] v, input logic lst);
    rec_byte_t b;
    b.value = v;
    b.last  = lst;
    rec_bytes_q.insert(rec_bytes_q.size(), b);
  endfunction

  function automatic void close_chunk(input logic [brc_pkg::POS_W-1:0] pos);
    logic [63:0] pos64;
    int          w;
    logic        last_letter;
    pos64 = {16'd0, pos};
    for (int j = 0; j < 8; j++) begin
      add_byte(pos64[8*j +: 8], 1'b0);
    end
    for (int i = 0; i < ALPHABET; i++) begin
      w = count_width(letter_cnt[i]);
      last_letter = (i == ALPHABET - 1);
      add_byte(8'(w), last_letter && (w == 0));
      for (int j = 0; j < w; j++) begin
        add_byte(letter_cnt[i][8*j +: 8], last_letter && (j == w - 1));
      end
      letter_cnt[i] = '0;
    end
    chunk_run_cnt = '0;
  endfunction

  function automatic void predict_run(input logic cmd,
                                      input logic [brc_pkg::PILE_W-1:0] pile,
                                      input logic [brc_pkg::LEN_W-1:0] len,
                                      input logic [brc_pkg::POS_W-1:0] pos);
    logic [brc_pkg::CNT_W:0] sum;
    if (cmd == CMD_FINISH) begin
      close_chunk(pos);
    end else begin
      if (pile < ALPHABET) begin
        sum = {1'b0, letter_cnt[pile]} + {33'd0, len};
        letter_cnt[pile] = sum[brc_pkg::CNT_W] ? '1 : sum[brc_pkg::CNT_W-1:0];
      end
      chunk_run_cnt = chunk_run_cnt + 1'b1;
      if (chunk_run_cnt == chunk_runs) begin
        close_chunk(pos);
      end
    end
  endfunction

  task automatic send_run(input logic cmd, input logic [brc_pkg::PILE_W-1:0] pile,
                          input logic [brc_pkg::LEN_W-1:0] len,
                          input logic [brc_pkg::POS_W-1:0] pos);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'd0, pos, len, pile};
    do @(posedge clk); while (!s_tready);
    predict_run(cmd, pile, len, pos);
  endtask

  task automatic drain_records();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rec_bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_chunk_runs(input logic [brc_pkg::RPC_W-1:0] v);
    drain_records();
    repeat (REC_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    chunk_runs  = v;
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  function automatic logic [brc_pkg::LEN_W-1:0] rand_len();
    case ($urandom_range(3))
      0:       return '0;
      1:       return LEN_MAX;
      2:       return brc_pkg::LEN_W'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [brc_pkg::POS_W-1:0] rand_pos();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[brc_pkg::POS_W-1:0];
  endfunction

  // reset chunk size; every pile, length extremes, bad piles, empty finish
  task automatic test_default_chunk();
    send_run(CMD_RUN, 3'd0, '0, rand_pos());
    send_run(CMD_RUN, 3'd1, 32'd1, rand_pos());
    send_run(CMD_RUN, 3'd2, LEN_MAX, rand_pos());
    send_run(CMD_RUN, 3'd3, 32'h100, rand_pos());
    send_run(CMD_RUN, 3'd4, 32'h1_0000, rand_pos());
    send_run(CMD_RUN, 3'd5, LEN_MAX, rand_pos());
    send_run(CMD_RUN, 3'd5, LEN_MAX, rand_pos());
    send_run(CMD_RUN, 3'd6, 32'd5, rand_pos());
    send_run(CMD_RUN, 3'd7, 32'hFFFF, rand_pos());
    send_run(CMD_FINISH, 3'd7, LEN_MAX, POS_MAX);
    send_run(CMD_FINISH, 3'd0, '0, '0);
  endtask

  task automatic test_single_run_chunks();
    set_chunk_runs(16'd1);
    send_run(CMD_RUN, 3'd5, LEN_MAX, 48'h0123_4567_89AB);
    send_run(CMD_RUN, 3'd7, 32'd1, '0);
    send_run(CMD_FINISH, 3'd0, '0, 48'd1);
  endtask

  // chunk size lowered below the run counter: no record until finish
  task automatic test_chunk_shrink();
    set_chunk_runs(16'hFFFF);
    repeat (5) send_run(CMD_RUN, 3'($urandom_range(5)), rand_len(), rand_pos());
    set_chunk_runs(16'd3);
    repeat (2) send_run(CMD_RUN, 3'($urandom_range(7)), rand_len(), rand_pos());
    send_run(CMD_FINISH, 3'($urandom_range(7)), rand_len(), rand_pos());
  endtask

  // zero chunk size: the run counter does not match before it wraps
  task automatic test_counter_wrap();
    logic [brc_pkg::LEN_W-1:0] len;
    repeat (2) send_run(CMD_RUN, 3'($urandom_range(5)), LEN_MAX, rand_pos());
    set_chunk_runs(16'd0);
    for (int i = 0; i < 10; i++) begin
      len = $urandom_range(1) ? LEN_MAX : $urandom;
      send_run(CMD_RUN, 3'($urandom_range(7)), len, rand_pos());
    end
    send_run(CMD_FINISH, 3'($urandom_range(7)), rand_len(), rand_pos());
  endtask

  task automatic test_random_runs(input int n_runs);
    logic cmd;
    send_run(CMD_FINISH, 3'($urandom_range(7)), rand_len(), rand_pos());
    set_chunk_runs(brc_pkg::RPC_W'($urandom_range(1, 6)));
    for (int i = 0; i < n_runs; i++) begin
      if (i == n_runs / 2) begin
        drain_records();
      end
      cmd = ($urandom_range(99) < 8) ? CMD_FINISH : CMD_RUN;
      send_run(cmd, 3'($urandom_range(7)), rand_len(), rand_pos());
    end
  endtask

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    chunk_run_cnt = '0;
    chunk_runs = brc_pkg::RPC_RESET;
    for (int i = 0; i < ALPHABET; i++) begin
      letter_cnt[i] = '0;
    end
    set_idling(0, 0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(21, 79);
    test_default_chunk();
    test_single_run_chunks();
    test_chunk_shrink();
    test_counter_wrap();
    test_random_runs(60);

    set_idling(79, 21);
    test_random_runs(60);
    set_idling(0, 0);
    test_random_runs(60);

    drain_records();
    repeat (REC_SETTLE) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### bwt_rank_checkpoint_builder.f
design/brc_pkg.sv
design/brc_front.sv
design/brc_queue.sv
design/brc_ser.sv
design/bwt_rank_checkpoint_builder.sv
tb/tb.sv
